[rtl/bale_pkg.sv]
// shared types and codes of the bounded array list engine
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

  // position width, covers counts up to the largest supported depth
  localparam int POS_W = 11;

  // operation selector codes
  typedef enum logic [2:0] {
    FN_SET     = 3'd0,
    FN_APPEND  = 3'd1,
    FN_GET     = 3'd2,
    FN_DELETE  = 3'd3,
    FN_REPLACE = 3'd4,
    FN_SIZE    = 3'd5
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CAP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_COUNT = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_GATHER = 2'd1,
    S_FINISH = 2'd2
  } state_e;

  // register word index of the capacity register
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // command broadcast to every slot cell
  typedef struct packed {
    logic             load;
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic             fill_en;
    logic [POS_W-1:0] fill_lo;
    logic [POS_W-1:0] fill_hi;
    logic             shift_en;
    logic [POS_W-1:0] shift_lo;
    logic [POS_W-1:0] shift_hi;
    logic             get_en;
    logic [POS_W-1:0] get_pos;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/bale_cell.sv]
// one slot cell of the list: holds a word, takes its right neighbor on a shift
`timescale 1ns / 1ps
`default_nettype none

module bale_cell #(
  parameter int WORD_W   = 32,
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  bale_pkg::cmd_t      cmd_i,
  input  logic [WORD_W-1:0]   wr_data_i,
  input  logic [WORD_W-1:0]   nbr_i,
  output logic [WORD_W-1:0]   word_o,
  output logic [WORD_W-1:0]   tap_o
);

  localparam logic [bale_pkg::POS_W-1:0] Pos = bale_pkg::POS_W'(CELL_IDX);

  logic [WORD_W-1:0] word_d, word_q;
  logic [WORD_W-1:0] tap_d, tap_q;

  always_comb begin
    word_d = word_q;
    tap_d  = tap_q;
    if (cmd_i.load) begin
      // read tap is zero unless this cell is the one being read
      tap_d = (cmd_i.get_en && (cmd_i.get_pos == Pos)) ? word_q : '0;
      if (cmd_i.wr_en && (cmd_i.wr_pos == Pos)) begin
        word_d = wr_data_i;
      end else if (cmd_i.fill_en && (Pos >= cmd_i.fill_lo) && (Pos < cmd_i.fill_hi)) begin
        word_d = '0;
      end else if (cmd_i.shift_en && (Pos >= cmd_i.shift_lo) && (Pos < cmd_i.shift_hi)) begin
        word_d = nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    tap_q  <= tap_d;
  end

  assign word_o = word_q;
  assign tap_o  = tap_q;

endmodule

`default_nettype wire

[rtl/bale_gather.sv]
// registered or-tree that collects the read taps of all cells
`timescale 1ns / 1ps
`default_nettype none

module bale_gather #(
  parameter int DEPTH  = 64,
  parameter int WORD_W = 32
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [WORD_W-1:0] taps_i [DEPTH],
  output logic [WORD_W-1:0] data_o
);

  localparam int GrpSize = 8;
  localparam int NumGrp  = (DEPTH + GrpSize - 1) / GrpSize;

  logic [WORD_W-1:0] grp_d [NumGrp];
  logic [WORD_W-1:0] grp_q [NumGrp];

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSize; k++) begin
        if (g * GrpSize + k < DEPTH) begin
          grp_d[g] = grp_d[g] | taps_i[g * GrpSize + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      data_o = data_o | grp_q[g];
    end
  end

endmodule

`default_nettype wire

[rtl/bounded_array_list_engine.sv]
// top level of the bounded array list engine: sequencer, registers, cell row
`timescale 1ns / 1ps
`default_nettype none

// A bounded list of WORD_W-bit words held in a row of DEPTH slot cells. Each request
// carries an operation (tuser: set at index, append, get, delete, replace, size query),
// an index and a value, and gives exactly one result: a status (tuser), the word read
// by a get and the entry count after the operation. Set, append, replace, the zero
// fill of a gap and the shift-down of a delete all happen in the cells at the edge
// that accepts the request. The read data then passes the registered cell taps and a
// two-stage or-tree, whose group stage is registered, into the result register, and a new
// request is taken only once the last one has loaded its result; a result that is still
// waiting does not block the next acceptance, only the final stage of the following request.
// The capacity register (byte address 0, reset 64) limits set and append; values above
// DEPTH act as DEPTH. Write it only while no request is in flight.
module bounded_array_list_engine #(
  parameter int DEPTH  = 64,
  parameter int WORD_W = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // index[5:0], value[37:6], zero pad
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data[31:0], count[38:32], zero pad
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PosW = bale_pkg::POS_W;
  localparam int CntW = $clog2(DEPTH + 1);

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic [6:0] capacity_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == bale_pkg::REG_CAPACITY);
  assign prdata = (paddr[2:2] == bale_pkg::REG_CAPACITY) ? 32'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 7'd64;
    end else if (cfg_wr) begin
      capacity_q <= pwdata[6:0];
    end
  end

  // ---------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------
  bale_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [1:0]        pend_status_q, pend_status_d;
  logic              accept;

  logic [2:0]        in_func;
  logic [5:0]        in_index;
  logic [31:0]       in_value;
  logic [PosW-1:0]   idx_w, cnt_w, cap_w;
  bale_pkg::cmd_t    cmd;

  assign in_index = s_axis_tdata[5:0];
  assign in_value = s_axis_tdata[37:6];
  assign in_func  = s_axis_tuser;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign idx_w = PosW'(in_index);
  assign cnt_w = PosW'(count_q);
  // capacity above the store depth acts as the depth
  assign cap_w = (PosW'(capacity_q) > PosW'(DEPTH)) ? PosW'(DEPTH) : PosW'(capacity_q);

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    count_d       = count_q;
    pend_status_d = pend_status_q;
    if (accept) begin
      pend_status_d = bale_pkg::ST_OK;
      case (in_func)
        bale_pkg::FN_SET: begin
          if (idx_w >= cap_w) begin
            pend_status_d = bale_pkg::ST_CAP;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_pos = idx_w;
            if (idx_w >= cnt_w) begin
              // zero fill the gap and grow to end just after the slot
              cmd.fill_en = 1'b1;
              cmd.fill_lo = cnt_w;
              cmd.fill_hi = idx_w;
              count_d     = CntW'(idx_w + PosW'(1));
            end
          end
        end
        bale_pkg::FN_APPEND: begin
          if (cnt_w >= cap_w) begin
            pend_status_d = bale_pkg::ST_FULL;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_pos = cnt_w;
            count_d    = CntW'(cnt_w + PosW'(1));
          end
        end
        bale_pkg::FN_GET: begin
          if (idx_w >= cnt_w) begin
            pend_status_d = bale_pkg::ST_COUNT;
          end else begin
            cmd.get_en  = 1'b1;
            cmd.get_pos = idx_w;
          end
        end
        bale_pkg::FN_DELETE: begin
          if (idx_w >= cnt_w) begin
            pend_status_d = bale_pkg::ST_COUNT;
          end else begin
            // cells from the index up to the one before the last entry take their right neighbor
            cmd.shift_en = 1'b1;
            cmd.shift_lo = idx_w;
            cmd.shift_hi = cnt_w - PosW'(1);
            count_d      = CntW'(cnt_w - PosW'(1));
          end
        end
        bale_pkg::FN_REPLACE: begin
          if (idx_w >= cnt_w) begin
            pend_status_d = bale_pkg::ST_COUNT;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_pos = idx_w;
          end
        end
        default: begin
          // size query and unused selectors change nothing
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // row of slot cells, each fed by its right neighbor, the last one by zero
  // ---------------------------------------------------------------
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] words [DEPTH];
  logic [WORD_W-1:0] taps  [DEPTH];

  assign wr_data = WORD_W'(in_value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = words[i+1];
    end
    bale_cell #(
      .WORD_W  (WORD_W),
      .CELL_IDX(i)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .wr_data_i(wr_data),
      .nbr_i    (nbr),
      .word_o   (words[i]),
      .tap_o    (taps[i])
    );
  end

  // ---------------------------------------------------------------
  // read collection
  // ---------------------------------------------------------------
  logic              grp_load;
  logic [WORD_W-1:0] gather_data;

  bale_gather #(
    .DEPTH (DEPTH),
    .WORD_W(WORD_W)
  ) u_gather (
    .clk_i (clk_i),
    .load_i(grp_load),
    .taps_i(taps),
    .data_o(gather_data)
  );

  // ---------------------------------------------------------------
  // sequencer and result register
  // ---------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [31:0] out_data_q;
  logic [1:0]  out_status_q;
  logic [6:0]  out_count_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    grp_load      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      bale_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = bale_pkg::S_GATHER;
        end
      end
      bale_pkg::S_GATHER: begin
        grp_load = 1'b1;
        state_d  = bale_pkg::S_FINISH;
      end
      bale_pkg::S_FINISH: begin
        // wait here while the previous result is still not taken
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = bale_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bale_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bale_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    if (out_load) begin
      out_data_q   <= 32'(gather_data);
      out_status_q <= pend_status_q;
      out_count_q  <= 7'(count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_data_q};

`ifndef SYNTH
  // the entry count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  // an accepted request always moves on to the read collection
  a_accept_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == bale_pkg::S_GATHER)
    else $error("accepted request did not enter gather");

  // a failed operation leaves the count as it was
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pend_status_d != bale_pkg::ST_OK) |=> $stable(count_q))
    else $error("failed operation changed the count");

  // a pending result that is not taken holds the final stage
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bale_pkg::S_FINISH) && out_valid_q && !m_axis_tready
      |=> state_q == bale_pkg::S_FINISH)
    else $error("result overwritten before it was taken");

  // fill and shift never act in the same request
  a_fill_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(cmd.fill_en && cmd.shift_en))
    else $error("fill and shift in one request");
`endif

endmodule

`default_nettype wire

[tb/sv/list_result_checker.sv]
// result predictor and checker for the bounded array list engine
`timescale 1ns / 1ps

module list_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // index[5:0], value[37:6], zero pad
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // data[31:0], count[38:32], zero pad
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_o,
  output int          error_count_o
);

  localparam int         DEPTH          = 64;
  localparam logic [6:0] CAPACITY_RESET = 7'd64;
  localparam logic [2:0] CAPACITY_ADDR  = {bale_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    bale_pkg::status_e status;
    logic [31:0]       data;
    logic [6:0]        count;
  } list_result_t;

  logic [31:0]  list_words [DEPTH];
  logic [6:0]   list_len;
  logic [6:0]   cap_reg;
  list_result_t expected_results [$];
  list_result_t want;
  logic [1:0]   got_status;
  logic [31:0]  got_data;
  logic [6:0]   got_count;

  // applies one request to the shadow list and returns its result
  function automatic list_result_t predict_list_op(logic [2:0] op, logic [5:0] idx,
                                                   logic [31:0] word);
    list_result_t res;
    int usable;
    int pos;
    int n;
    usable     = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    pos        = int'(idx);
    n          = int'(list_len);
    res.status = bale_pkg::ST_OK;
    res.data   = '0;
    case (op)
      bale_pkg::FN_SET: begin
        if (pos >= usable) begin
          res.status = bale_pkg::ST_CAP;
        end else begin
          if (pos >= n) begin
            for (int i = n; i < pos; i++) list_words[i] = '0;
            n = pos + 1;
          end
          list_words[pos] = word;
        end
      end
      bale_pkg::FN_APPEND: begin
        if (n >= usable || n >= DEPTH) begin
          res.status = bale_pkg::ST_FULL;
        end else begin
          list_words[n] = word;
          n++;
        end
      end
      bale_pkg::FN_GET: begin
        if (pos >= n) res.status = bale_pkg::ST_COUNT;
        else res.data = list_words[pos];
      end
      bale_pkg::FN_DELETE: begin
        if (pos >= n) begin
          res.status = bale_pkg::ST_COUNT;
        end else begin
          for (int i = pos; i + 1 < n; i++) list_words[i] = list_words[i + 1];
          n--;
        end
      end
      bale_pkg::FN_REPLACE: begin
        if (pos >= n) res.status = bale_pkg::ST_COUNT;
        else list_words[pos] = word;
      end
      default: begin
      end
    endcase
    list_len  = n[6:0];
    res.count = list_len;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = '0;
      cap_reg  = CAPACITY_RESET;
      expected_results.delete();
      pending_o     = 0;
      error_count_o = 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tuser;
        got_data   = m_axis_tdata[31:0];
        got_count  = m_axis_tdata[38:32];
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d data %h count %0d",
                 got_status, got_data, got_count);
          error_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            error_count_o++;
          end
          if (got_data !== want.data) begin
            $error("data: expected %h, actual %h", want.data, got_data);
            error_count_o++;
          end
          if (got_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got_count);
            error_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
        cap_reg = pwdata[6:0];
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_list_op(s_axis_tuser, s_axis_tdata[5:0],
                                                   s_axis_tdata[37:6]));
      pending_o = expected_results.size();
    end
  end

endmodule

[tb/sv/bounded_array_list_engine_test.sv]
// stimulus and verdict for the bounded array list engine
`timescale 1ns / 1ps

module bounded_array_list_engine_test;

  // unused selectors, the block must treat them as no-ops
  localparam logic [2:0] FN_SPARE_LO   = 3'd6;
  localparam logic [2:0] FN_SPARE_HI   = 3'd7;
  localparam logic [2:0] CAPACITY_ADDR = {bale_pkg::REG_CAPACITY, 2'b00};
  localparam int         SEGMENT_ITEMS = 225;
  localparam int         SEGMENTS      = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // index[5:0], value[37:6], zero pad
  logic [2:0]  s_axis_tuser  = '0;   // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // data[31:0], count[38:32], zero pad
  logic [1:0]  m_axis_tuser;         // status[1:0]
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int error_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // capacity per random segment: extremes, above depth, odd sizes; slot 6 is drawn
  int capacity_plan [SEGMENTS] = '{64, 1, 127, 0, 17, 64, 0, 100};

  bounded_array_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  list_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request: random idle cycles first, then hold until the block takes it
  // called and returns at a rising edge
  task automatic send_request(logic [2:0] op, logic [5:0] idx, logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, word, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait for every outstanding result, returns at a falling edge
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // apb write of the capacity register, called at a falling edge while idle,
  // returns at a rising edge
  task automatic write_capacity(logic [6:0] cap);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {25'd0, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // operation mix: growing segments favor append and set, churn favors delete
  function automatic logic [2:0] pick_op(bit grow);
    int r;
    r = $urandom_range(99);
    if (r >= 97) return ($urandom_range(1) != 0) ? FN_SPARE_HI : FN_SPARE_LO;
    if (grow) begin
      if (r < 30) return bale_pkg::FN_APPEND;
      if (r < 45) return bale_pkg::FN_SET;
      if (r < 65) return bale_pkg::FN_GET;
      if (r < 75) return bale_pkg::FN_DELETE;
      if (r < 88) return bale_pkg::FN_REPLACE;
    end else begin
      if (r < 15) return bale_pkg::FN_APPEND;
      if (r < 30) return bale_pkg::FN_SET;
      if (r < 55) return bale_pkg::FN_GET;
      if (r < 80) return bale_pkg::FN_DELETE;
      if (r < 92) return bale_pkg::FN_REPLACE;
    end
    return bale_pkg::FN_SIZE;
  endfunction

  // word values lean toward the extremes now and then
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  initial begin
    int cap_set;
    int idx_hi;
    logic [5:0] idx;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: every index lookup misses, size is zero
    send_request(bale_pkg::FN_GET, 6'd0, 32'h0);
    send_request(bale_pkg::FN_DELETE, 6'd0, 32'h0);
    send_request(bale_pkg::FN_REPLACE, 6'd0, 32'hFFFF_FFFF);
    send_request(bale_pkg::FN_SIZE, 6'd63, 32'h0);
    // growth by append, then a set past the end with a zero-filled gap
    send_request(bale_pkg::FN_APPEND, 6'd0, 32'hFFFF_FFFF);
    send_request(bale_pkg::FN_APPEND, 6'd63, 32'h0);
    send_request(bale_pkg::FN_SET, 6'd5, 32'hA5A5_A5A5);
    send_request(bale_pkg::FN_GET, 6'd3, 32'h0);
    send_request(bale_pkg::FN_GET, 6'd5, 32'h0);
    // fill to the top slot, append on a full list, overwrite the top slot
    send_request(bale_pkg::FN_SET, 6'd63, 32'h1234_5678);
    send_request(bale_pkg::FN_APPEND, 6'd0, 32'h0000_0001);
    send_request(bale_pkg::FN_SET, 6'd63, 32'h8000_0000);
    send_request(bale_pkg::FN_GET, 6'd63, 32'h0);
    // delete at the head shifts everything down, delete of the last entry
    send_request(bale_pkg::FN_DELETE, 6'd0, 32'h0);
    send_request(bale_pkg::FN_GET, 6'd0, 32'h0);
    send_request(bale_pkg::FN_DELETE, 6'd62, 32'h0);
    send_request(bale_pkg::FN_GET, 6'd62, 32'h0);
    send_request(bale_pkg::FN_REPLACE, 6'd10, 32'hDEAD_BEEF);
    send_request(bale_pkg::FN_GET, 6'd10, 32'h0);
    send_request(FN_SPARE_LO, 6'd63, 32'hFFFF_FFFF);
    send_request(FN_SPARE_HI, 6'd0, 32'h0);
    // zero capacity: set reports capacity, append reports full
    wait_idle();
    write_capacity(7'd0);
    send_request(bale_pkg::FN_SET, 6'd0, 32'h5555_5555);
    send_request(bale_pkg::FN_APPEND, 6'd0, 32'hAAAA_AAAA);
    // capacity lowered below the count: entries stay, set below it still works
    wait_idle();
    write_capacity(7'd1);
    send_request(bale_pkg::FN_SET, 6'd0, 32'h0F0F_0F0F);
    send_request(bale_pkg::FN_SET, 6'd1, 32'hF0F0_F0F0);
    send_request(bale_pkg::FN_APPEND, 6'd0, 32'h1);
    // capacity above depth acts as depth
    wait_idle();
    write_capacity(7'd127);
    send_request(bale_pkg::FN_SET, 6'd63, 32'h7777_7777);
    send_request(bale_pkg::FN_APPEND, 6'd0, 32'h2);

    // random segments, each with its own capacity and idling phase
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      cap_set = (seg == 6) ? $urandom_range(1, 64) : capacity_plan[seg];
      write_capacity(cap_set[6:0]);
      // half the indexes land below the capacity so lookups tend to hit
      idx_hi = (cap_set == 0) ? 0 : ((cap_set > 64) ? 63 : cap_set - 1);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (seg == 2 && n == SEGMENT_ITEMS / 2) begin
          // hold the request side until the block has drained
          wait_idle();
          @(posedge clk_i);
        end
        if ($urandom_range(1) != 0) idx = 6'($urandom_range(63));
        else idx = 6'($urandom_range(idx_hi));
        send_request(pick_op(seg % 2 == 0), idx, pick_word());
      end
    end

    wait_idle();
    repeat (12) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("** bounded_array_list_engine: PASSED **");
    end else begin
      $display("** bounded_array_list_engine: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("** bounded_array_list_engine: FAILED **");
    $finish;
  end

endmodule

[bounded_array_list_engine.f]
rtl/bale_pkg.sv
rtl/bale_cell.sv
rtl/bale_gather.sv
rtl/bounded_array_list_engine.sv
tb/sv/list_result_checker.sv
tb/sv/bounded_array_list_engine_test.sv
